FILE: hw/rtl/tma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Shared constants, transaction types and divider constants for the trimmed
// moving average unit.
// ----------------------------------------------------------------------------
package tma_pkg;

    // Filter geometry.
    localparam int WINDOW    = 10;
    localparam int CHANNELS  = 3;
    localparam int HIST_LEN  = WINDOW - 1;
    localparam int MEM_DEPTH = CHANNELS * HIST_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int IDX_W     = $clog2(HIST_LEN);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int MEAN_W   = 20;

    // Constant divider: mean = trimmed * 16 / DIV_D, by reciprocal and correction.
    localparam int DIV_D     = WINDOW - 2;
    localparam int DIVISOR_W = $clog2(DIV_D + 1);
    localparam int SCALED_W  = SUM_W + 4;
    localparam int DIV_SHIFT = SCALED_W + 1;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SCALED_W + RECIP_W;
    localparam int QD_W      = SCALED_W + DIVISOR_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / DIV_D);

    // Input transaction.
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic signed [SUM_W-1:0]  trimmed_sum;
        logic signed [MEAN_W-1:0] mean_q4;
    } t_out;

endpackage

FILE: hw/rtl/tma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_div
// Three-stage signed divide of (value * 16) by the constant WINDOW-2, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tma_div
    import tma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_value,
    output logic                     o_done,
    output logic signed [MEAN_W-1:0] o_quot
);

    logic [SUM_W-1:0]    mag;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] q0;
    logic [QD_W-1:0]     rem;
    logic [SCALED_W-1:0] q_fix;
    logic [SCALED_W-1:0] q_signed;

    logic                r_v1, r_v2, r_done;
    logic                r_neg1, r_neg2;
    logic [PROD_W-1:0]   r_prod;
    logic [SCALED_W-1:0] r_m1, r_m2;
    logic [SCALED_W-1:0] r_q0;
    logic [QD_W-1:0]     r_qd;
    logic signed [MEAN_W-1:0] r_quot;

    // Magnitude of the dividend, scaled to Q4.
    assign mag    = i_value[SUM_W-1] ? SUM_W'(-i_value) : SUM_W'(i_value);
    assign scaled = {mag, 4'b0000};

    // Estimated quotient is exact or one short.
    assign q0 = r_prod[DIV_SHIFT +: SCALED_W];

    // Remainder check corrects the estimate, then the sign is restored.
    assign rem      = QD_W'(r_m2) - r_qd;
    assign q_fix    = (rem >= QD_W'(DIV_D)) ? r_q0 + SCALED_W'(1) : r_q0;
    assign q_signed = r_neg2 ? SCALED_W'(-q_fix) : q_fix;

    // Stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_v2) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(scaled) * PROD_W'(DIV_RECIP);
            r_m1   <= scaled;
            r_neg1 <= i_value[SUM_W-1];
        end
        if (r_v1) begin
            r_q0   <= q0;
            r_qd   <= QD_W'(q0) * QD_W'(DIV_D);
            r_m2   <= r_m1;
            r_neg2 <= r_neg1;
        end
        if (r_v2) begin
            r_quot <= MEAN_W'(q_signed);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/trimmed_moving_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_moving_average_unit
// Per-channel trimmed-mean moving average over a window of signed samples.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one sample and its channel number per transaction.
// For each transaction the unit returns one output transaction: the window sum
// (new sample plus that channel's WINDOW-1 stored samples) less one largest and
// one smallest value, and that trimmed sum times 16 divided by WINDOW-2,
// truncated toward zero. A channel number at or above CHANNELS yields zeros and
// leaves all histories untouched.
// The unit works on one transaction at a time. The history entries are read
// one per cycle through the single read port of the sample memory, and
// o_in_stall stays high from acceptance until the result enters the output
// register, when the input opens again. A new transaction may be accepted
// while the previous result still waits in the output register.
// Reset clears every history to zero through per-entry valid bits and empties
// the output register. While i_out_stall is high the result holds and the
// next result waits inside the unit.
// ----------------------------------------------------------------------------
module trimmed_moving_average_unit
    import tma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_TRIM = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0] r_state, n_state;

    logic                       r_out_valid;
    t_out                       r_out_data;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [CH_IDX_W-1:0]        r_ch;
    logic [ADDR_W-1:0]          r_base;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_ptr [CHANNELS];
    logic [MEM_DEPTH-1:0]       r_vld;
    logic signed [SUM_W-1:0]    r_sum, r_hi, r_lo, r_trim;
    logic                       r_acc;
    logic                       r_start;
    logic [SAMPLE_W-1:0]        r_rd_data;
    logic                       r_rd_vld;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

    logic                    in_acc;
    logic                    out_free;
    logic                    in_range;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [SUM_W-1:0] rd_val;
    logic signed [SUM_W-1:0] new_val;
    logic                    div_done;
    logic signed [MEAN_W-1:0] div_quot;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = 32'(i_in_data.channel) < CHANNELS;

    // Sample memory access: one read per scan cycle, one write at the end.
    assign rd_en   = (r_state == S_SCAN);
    assign rd_addr = r_base + ADDR_W'(r_idx);
    assign wr_en   = (r_state == S_LAST);
    assign wr_addr = r_base + ADDR_W'(r_ptr[r_ch]);

    assign rd_val  = r_rd_vld ? SUM_W'(signed'(r_rd_data)) : '0;
    assign new_val = SUM_W'(i_in_data.sample);

    // Sample memory, no reset.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= r_sample;
        end
    end

    // Entry valid bits and per-channel oldest-entry pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c] <= '0;
            end
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
                r_ptr[r_ch] <= (r_ptr[r_ch] == IDX_W'(HIST_LEN - 1)) ?
                               '0 : r_ptr[r_ch] + IDX_W'(1);
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = in_range ? S_SCAN : S_TRIM;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_W'(HIST_LEN - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_TRIM;
            end
            S_TRIM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done && !r_start && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= rd_en;
            r_start <= (r_state == S_TRIM);
            if (r_state == S_DIV && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window accumulation: sum, largest and smallest value.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_in_data.sample;
            r_ch     <= CH_IDX_W'(i_in_data.channel);
            r_base   <= ADDR_W'(32'(i_in_data.channel) * HIST_LEN);
            r_idx    <= '0;
            r_sum    <= in_range ? new_val : '0;
            r_hi     <= in_range ? new_val : '0;
            r_lo     <= in_range ? new_val : '0;
        end else begin
            if (rd_en) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_acc) begin
                r_sum <= r_sum + rd_val;
                if (rd_val > r_hi) begin
                    r_hi <= rd_val;
                end
                if (rd_val < r_lo) begin
                    r_lo <= rd_val;
                end
            end
        end
        if (r_state == S_TRIM) begin
            r_trim <= r_sum - r_hi - r_lo;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && n_state == S_IDLE) begin
            r_out_data.trimmed_sum <= r_trim;
            r_out_data.mean_q4     <= div_quot;
        end
    end

    tma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_value (r_trim),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/tma_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_chk
// Port-level checks for the trimmed moving average unit, bound to the top.
// ----------------------------------------------------------------------------
module tma_chk
    import tma_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input t_out o_out_data,
    input logic i_out_stall
);

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // One transaction at a time: the input stalls right after an acceptance.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an item is in progress");

    // The mean carries the sign of the trimmed sum.
    a_mean_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.mean_q4 != '0) |->
            (o_out_data.mean_q4[MEAN_W-1] == o_out_data.trimmed_sum[SUM_W-1]))
        else $error("mean sign differs from trimmed sum sign");

    // Reset leaves the unit idle with an empty output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("unit not idle after reset");

endmodule

bind trimmed_moving_average_unit tma_chk u_tma_chk (.*);
